// ===== hdl/vlep_pkg.sv =====
// Shared types, constants and codes for the variable-latency execution pipeline.
`timescale 1ns / 1ps
package vlep_pkg;

  // Pipeline geometry.
  localparam int PIPE_DEPTH = 16;
  localparam int MASK_BITS  = 64;

  localparam int PIPE_IDX_W = $clog2(PIPE_DEPTH);
  localparam int MASK_IDX_W = $clog2(MASK_BITS);
  localparam int FLIGHT_W   = $clog2(PIPE_DEPTH + 1);

  // Front-to-back item queue.
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  // Field widths of the beats.
  localparam int LAT_W    = 6;
  localparam int CNT_W    = 6;
  localparam int WARP_W   = 16;
  localparam int KERNEL_W = 8;
  localparam int WORD_W   = 32;

  // Input mode codes.
  localparam logic [1:0] MODE_TICK  = 2'd0;
  localparam logic [1:0] MODE_ISSUE = 2'd1;

  typedef enum logic [1:0] {
    OP_TICK,
    OP_ISSUE,
    OP_QUERY
  } op_t;

  typedef enum logic [1:0] {
    KIND_RETIRE   = 2'd0,
    KIND_MOVE     = 2'd1,
    KIND_DISPATCH = 2'd2,
    KIND_STATUS   = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    BS_IDLE,
    BS_RETIRE,
    BS_SHIFT,
    BS_MOVE,
    BS_DISP,
    BS_STATUS
  } back_state_t;

  typedef struct packed {
    op_t                 op;
    logic                port_free;
    logic [WORD_W-1:0]   pc;
    logic [WARP_W-1:0]   warp;
    logic [KERNEL_W-1:0] kernel;
    logic [WORD_W-1:0]   serial;
    logic [LAT_W-1:0]    latency;
    logic [LAT_W-1:0]    interval;
    logic [CNT_W-1:0]    count;
  } item_t;

  typedef struct packed {
    kind_t               kind;
    logic                entry_valid;
    logic [WARP_W-1:0]   warp;
    logic [KERNEL_W-1:0] kernel;
    logic [WORD_W-1:0]   serial;
    logic [WORD_W-1:0]   pc;
    logic                may_issue;
    logic                issue_refused;
    logic                last;
  } result_t;

endpackage

// ===== hdl/variable_latency_exec_pipeline_top.sv =====
// Top level of the variable-latency execution pipeline: front end, item queue and back end.
`timescale 1ns / 1ps
// Usage:
// The input channel (in_valid/in_ready) takes one beat per item: a tick that advances the
// execution unit by one clock, an issue that loads the dispatch register, or a query that
// asks whether an instruction of a given latency may issue. The output channel
// (out_valid/out_ready) returns the result beats of each item in order; the final beat of
// every item is a status beat with last set.
// A query or issue passes from idle to the status state. A tick passes through the
// retire, shift, dispatch and status states, with one move beat per moved-down stage
// between shift and dispatch. The back end sequencer produces at most one result beat per
// cycle while the output is not stalled and works on one item at a time, taking a new item
// only once it is idle again. The front end queue holds two more items, so in_ready stays
// high while the back end is busy until the queue fills.
// Reset clears the pipeline occupancy, the dispatch register, the countdown, the mask, the
// occupancy count and the queue. Stage payloads are not cleared.
// When the receiver holds out_ready low, the output register keeps its beat, the back end
// stops, and once the queue is full in_ready drops.
module variable_latency_exec_pipeline_top import vlep_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [1:0]          mode,
  input  logic                port_free,
  input  logic [WORD_W-1:0]   instr_pc,
  input  logic [WARP_W-1:0]   instr_warp,
  input  logic [KERNEL_W-1:0] instr_kernel,
  input  logic [WORD_W-1:0]   instr_serial,
  input  logic [LAT_W-1:0]    instr_latency,
  input  logic [LAT_W-1:0]    instr_interval,
  input  logic [CNT_W-1:0]    interval_count,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [1:0]          kind,
  output logic                entry_valid,
  output logic [WARP_W-1:0]   out_warp,
  output logic [KERNEL_W-1:0] out_kernel,
  output logic [WORD_W-1:0]   out_serial,
  output logic [WORD_W-1:0]   out_pc,
  output logic                may_issue,
  output logic                issue_refused,
  output logic                last
);

  logic    item_valid;
  logic    item_ready;
  item_t   item;
  result_t res;

  // The front end decodes the mode and buffers items so input beats keep flowing while the
  // back end works through a tick.
  vlep_front u_front (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .mode           (mode),
    .port_free      (port_free),
    .instr_pc       (instr_pc),
    .instr_warp     (instr_warp),
    .instr_kernel   (instr_kernel),
    .instr_serial   (instr_serial),
    .instr_latency  (instr_latency),
    .instr_interval (instr_interval),
    .interval_count (interval_count),
    .item_valid     (item_valid),
    .item_ready     (item_ready),
    .item           (item)
  );

  // The back end owns all execution state and drives the registered result beats.
  vlep_back u_back (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .res        (res)
  );

  assign kind          = res.kind;
  assign entry_valid   = res.entry_valid;
  assign out_warp      = res.warp;
  assign out_kernel    = res.kernel;
  assign out_serial    = res.serial;
  assign out_pc        = res.pc;
  assign may_issue     = res.may_issue;
  assign issue_refused = res.issue_refused;
  assign last          = res.last;

endmodule

// ===== hdl/vlep_front.sv =====
// Front end: accepts input beats, classifies the mode and queues items for the back end.
`timescale 1ns / 1ps
module vlep_front import vlep_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [1:0]          mode,
  input  logic                port_free,
  input  logic [WORD_W-1:0]   instr_pc,
  input  logic [WARP_W-1:0]   instr_warp,
  input  logic [KERNEL_W-1:0] instr_kernel,
  input  logic [WORD_W-1:0]   instr_serial,
  input  logic [LAT_W-1:0]    instr_latency,
  input  logic [LAT_W-1:0]    instr_interval,
  input  logic [CNT_W-1:0]    interval_count,
  output logic                item_valid,
  input  logic                item_ready,
  output item_t               item
);

  item_t                  queue [QUEUE_DEPTH];
  logic [QUEUE_IDX_W-1:0] wr_ptr;
  logic [QUEUE_IDX_W-1:0] rd_ptr;
  logic [QUEUE_CNT_W-1:0] count;
  item_t                  new_item;
  logic                   push;
  logic                   pop;

  always_comb begin
    new_item = '{op: OP_QUERY, port_free: port_free, pc: instr_pc, warp: instr_warp,
                 kernel: instr_kernel, serial: instr_serial, latency: instr_latency,
                 interval: instr_interval, count: interval_count};
    // Mode codes other than tick and issue, 2 and 3, both behave as a query.
    case (mode)
      MODE_TICK:  new_item.op = OP_TICK;
      MODE_ISSUE: new_item.op = OP_ISSUE;
      default:    new_item.op = OP_QUERY;
    endcase
  end

  assign in_ready   = (count != QUEUE_CNT_W'(QUEUE_DEPTH));
  assign item_valid = (count != '0);
  assign item       = queue[rd_ptr];
  assign push       = in_valid && in_ready;
  assign pop        = item_valid && item_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      queue[wr_ptr] <= new_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QUEUE_IDX_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QUEUE_IDX_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== hdl/vlep_back.sv =====
// Back end: pipeline stages, dispatch register, reservation mask and the result sequencer.
`timescale 1ns / 1ps
module vlep_back import vlep_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    item_valid,
  output logic    item_ready,
  input  item_t   item,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t res
);

  back_state_t state;
  back_state_t state_next;
  item_t       cur;

  logic [PIPE_DEPTH-1:0] stage_valid;
  logic [WARP_W-1:0]     stage_warp   [PIPE_DEPTH];
  logic [KERNEL_W-1:0]   stage_kernel [PIPE_DEPTH];
  logic [WORD_W-1:0]     stage_pc     [PIPE_DEPTH];
  logic [WORD_W-1:0]     stage_serial [PIPE_DEPTH];

  logic                  dv;
  logic [WORD_W-1:0]     d_pc;
  logic [WORD_W-1:0]     d_serial;
  logic [WARP_W-1:0]     d_warp;
  logic [KERNEL_W-1:0]   d_kernel;
  logic [LAT_W-1:0]      d_lat;
  logic [LAT_W-1:0]      d_ivl;
  logic [CNT_W-1:0]      cd;
  logic [MASK_BITS-1:0]  mask;
  logic [FLIGHT_W-1:0]   in_flight;
  logic [PIPE_IDX_W-1:0] idx;

  logic                  ofree;
  logic                  emit;
  result_t               res_next;
  logic                  load_cur;
  logic                  do_retire;
  logic                  do_shift;
  logic                  do_move;
  logic                  do_place;
  logic                  do_count;
  logic                  do_issue;
  logic                  do_mask_shift;
  logic                  empty_found;
  logic [PIPE_IDX_W-1:0] s0;
  logic [LAT_W:0]        diff;
  logic [PIPE_IDX_W-1:0] start;
  logic                  lat_ok;
  logic [MASK_IDX_W-1:0] lat_idx;
  logic [MASK_BITS-1:0]  mask_sh;

  // Lowest empty stage.
  always_comb begin
    empty_found = 1'b0;
    s0          = '0;
    for (int i = PIPE_DEPTH - 1; i >= 0; i--) begin
      if (!stage_valid[i]) begin
        empty_found = 1'b1;
        s0          = PIPE_IDX_W'(i);
      end
    end
  end

  // Start stage of the dispatched entry: latency minus interval, clamped to the row.
  always_comb begin
    diff = {1'b0, d_lat} - {1'b0, d_ivl};
    if (diff[LAT_W]) begin
      start = '0;
    end else if (diff >= (LAT_W + 1)'(PIPE_DEPTH)) begin
      start = PIPE_IDX_W'(PIPE_DEPTH - 1);
    end else begin
      start = diff[PIPE_IDX_W-1:0];
    end
  end

  assign lat_ok  = ({1'b0, cur.latency} < (LAT_W + 1)'(MASK_BITS));
  assign lat_idx = cur.latency[MASK_IDX_W-1:0];
  assign mask_sh = mask >> 1;
  assign ofree   = !out_valid || out_ready;

  always_comb begin
    state_next    = state;
    item_ready    = 1'b0;
    load_cur      = 1'b0;
    emit          = 1'b0;
    do_retire     = 1'b0;
    do_shift      = 1'b0;
    do_move       = 1'b0;
    do_place      = 1'b0;
    do_count      = 1'b0;
    do_issue      = 1'b0;
    do_mask_shift = 1'b0;
    res_next      = '0;
    res_next.kind = KIND_STATUS;
    case (state)
      BS_IDLE: begin
        item_ready = 1'b1;
        if (item_valid) begin
          load_cur   = 1'b1;
          state_next = (item.op == OP_TICK) ? BS_RETIRE : BS_STATUS;
        end
      end
      BS_RETIRE: begin
        if (ofree) begin
          if (stage_valid[0] && cur.port_free) begin
            do_retire            = 1'b1;
            emit                 = 1'b1;
            res_next.kind        = KIND_RETIRE;
            res_next.entry_valid = 1'b1;
            res_next.warp        = stage_warp[0];
            res_next.kernel      = stage_kernel[0];
            res_next.serial      = stage_serial[0];
            res_next.pc          = stage_pc[0];
          end
          state_next = BS_SHIFT;
        end
      end
      BS_SHIFT: begin
        if (in_flight != '0 && empty_found && s0 != PIPE_IDX_W'(PIPE_DEPTH - 1)) begin
          do_shift   = 1'b1;
          state_next = BS_MOVE;
        end else begin
          state_next = BS_DISP;
        end
      end
      BS_MOVE: begin
        // The row has already moved down; stage idx now holds what stood above it.
        if (ofree) begin
          do_move              = 1'b1;
          emit                 = 1'b1;
          res_next.kind        = KIND_MOVE;
          res_next.entry_valid = stage_valid[idx];
          res_next.warp        = stage_valid[idx] ? stage_warp[idx] : '0;
          if (idx == PIPE_IDX_W'(PIPE_DEPTH - 2)) begin
            state_next = BS_DISP;
          end
        end
      end
      BS_DISP: begin
        if (ofree) begin
          if (dv) begin
            if (cd == CNT_W'(1)) begin
              if (!stage_valid[start]) begin
                do_place             = 1'b1;
                emit                 = 1'b1;
                res_next.kind        = KIND_DISPATCH;
                res_next.entry_valid = 1'b1;
                res_next.warp        = d_warp;
              end
            end else begin
              do_count = 1'b1;
            end
          end
          state_next = BS_STATUS;
        end
      end
      BS_STATUS: begin
        if (ofree) begin
          emit          = 1'b1;
          res_next.kind = KIND_STATUS;
          res_next.last = 1'b1;
          case (cur.op)
            OP_ISSUE: begin
              res_next.issue_refused = dv;
              res_next.may_issue     = 1'b0;
              do_issue               = !dv;
            end
            OP_TICK: begin
              res_next.may_issue = !dv && !(lat_ok && mask_sh[lat_idx]);
              do_mask_shift      = 1'b1;
            end
            default: begin
              res_next.may_issue = !dv && !(lat_ok && mask[lat_idx]);
            end
          endcase
          state_next = BS_IDLE;
        end
      end
      default: begin
        state_next = BS_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BS_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load_cur) begin
      cur <= item;
    end
  end

  // Stage occupancy.
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= '0;
    end else begin
      if (do_retire) begin
        stage_valid[0] <= 1'b0;
      end
      if (do_shift) begin
        for (int s = 0; s < PIPE_DEPTH - 1; s++) begin
          if (s >= int'(s0)) begin
            stage_valid[s] <= stage_valid[s+1];
          end
        end
        stage_valid[PIPE_DEPTH-1] <= 1'b0;
      end
      if (do_place) begin
        stage_valid[start] <= 1'b1;
      end
    end
  end

  // Stage payload.
  always_ff @(posedge clk) begin
    if (do_shift) begin
      for (int s = 0; s < PIPE_DEPTH - 1; s++) begin
        if (s >= int'(s0)) begin
          stage_warp[s]   <= stage_warp[s+1];
          stage_kernel[s] <= stage_kernel[s+1];
          stage_pc[s]     <= stage_pc[s+1];
          stage_serial[s] <= stage_serial[s+1];
        end
      end
    end
    if (do_place) begin
      stage_warp[start]   <= d_warp;
      stage_kernel[start] <= d_kernel;
      stage_pc[start]     <= d_pc;
      stage_serial[start] <= d_serial;
    end
  end

  // Dispatch register, countdown, reservation mask, occupancy count and move index.
  always_ff @(posedge clk) begin
    if (rst) begin
      dv        <= 1'b0;
      cd        <= '0;
      mask      <= '0;
      in_flight <= '0;
      idx       <= '0;
    end else begin
      if (do_issue) begin
        dv <= 1'b1;
        cd <= cur.count;
        if (lat_ok) begin
          mask[lat_idx] <= 1'b1;
        end
      end
      if (do_place) begin
        dv <= 1'b0;
      end
      if (do_count) begin
        cd <= cd - 1'b1;
      end
      if (do_mask_shift) begin
        mask <= mask_sh;
      end
      if (do_retire && in_flight != '0) begin
        in_flight <= in_flight - 1'b1;
      end else if (do_place) begin
        in_flight <= in_flight + 1'b1;
      end
      if (do_shift) begin
        idx <= s0;
      end else if (do_move) begin
        idx <= idx + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_issue) begin
      d_pc     <= cur.pc;
      d_serial <= cur.serial;
      d_warp   <= cur.warp;
      d_kernel <= cur.kernel;
      d_lat    <= cur.latency;
      d_ivl    <= cur.interval;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      res <= res_next;
    end
  end

endmodule

// ===== hdl/vlep_checker.sv =====
// Port-level checker for the execution pipeline top level, with its bind statement.
`timescale 1ns / 1ps
module vlep_checker import vlep_pkg::*; (
  input logic                clk,
  input logic                rst,
  input logic                out_valid,
  input logic                out_ready,
  input logic [1:0]          kind,
  input logic                entry_valid,
  input logic [WARP_W-1:0]   out_warp,
  input logic [KERNEL_W-1:0] out_kernel,
  input logic [WORD_W-1:0]   out_serial,
  input logic [WORD_W-1:0]   out_pc,
  input logic                may_issue,
  input logic                issue_refused,
  input logic                last
);

  // A stalled result beat holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(kind) && $stable(entry_valid)
      && $stable(out_warp) && $stable(out_kernel) && $stable(out_serial)
      && $stable(out_pc) && $stable(may_issue) && $stable(issue_refused) && $stable(last))
    else $error("result beat changed while stalled");

  // Only the status beat closes an item.
  a_last_status: assert property (@(posedge clk) disable iff (rst)
    out_valid && (last != (kind == KIND_STATUS)) |-> 1'b0)
    else $error("last does not match the status beat");

  // Status flags appear only on status beats.
  a_flags_status: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind != KIND_STATUS |-> !may_issue && !issue_refused)
    else $error("status flags on a non-status beat");

  // A refused issue leaves the dispatch register full, so nothing may issue.
  a_refused_blocks: assert property (@(posedge clk) disable iff (rst)
    out_valid && issue_refused |-> !may_issue)
    else $error("may_issue set with a refused issue");

  // Retire and dispatch beats always carry an instruction.
  a_entry_valid: assert property (@(posedge clk) disable iff (rst)
    out_valid && (kind == KIND_RETIRE || kind == KIND_DISPATCH) |-> entry_valid)
    else $error("retire or dispatch beat without an entry");

endmodule

bind variable_latency_exec_pipeline_top vlep_checker u_vlep_checker (.*);
